/* rtl/bvh_pkg.sv */
// Shared types, constants and helper functions for the bucketed value histogram.
package bvh_pkg;

    // Sizing
    localparam int NUM_BOUNDS  = 7;
    localparam int COUNT_WIDTH = 32;
    localparam int NUM_BUCKETS = NUM_BOUNDS + 1;
    localparam int BKT_ADDR_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;

    // Fixed field widths
    localparam int OP_W     = 2;
    localparam int SAMPLE_W = 32;
    localparam int SEL_W    = 3;
    localparam int OUT_W    = 32;
    localparam int SUM_W    = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam logic [SUM_W-1:0]       SUM_MAX   = '1;
    localparam logic [63:0]            OUT_MAX64 = 64'h0000_0000_FFFF_FFFF;

    // Operation codes
    localparam logic [OP_W-1:0] OP_OBSERVE = 2'd0;
    localparam logic [OP_W-1:0] OP_READ    = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BOUNDS_IN_USE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUND_0       = 3'd1;

    typedef logic [SAMPLE_W-1:0] t_bound;

    typedef struct packed {
        logic [OP_W-1:0]     operation;
        logic [SAMPLE_W-1:0] sample;
        logic [SEL_W-1:0]    bucket_select;
    } t_in_item;

    typedef struct packed {
        logic [SEL_W-1:0] bin_index;
        logic [OUT_W-1:0] bin_count;
        logic [OUT_W-1:0] total_count;
        logic [SUM_W-1:0] total_sum;
    } t_out_item;

    // Classification result passed from the classifier to the counter core
    typedef struct packed {
        logic [SEL_W-1:0] hit;
    } t_class;

    // Clamp a counter value to the 32-bit output range
    function automatic logic [OUT_W-1:0] clamp_out(input logic [COUNT_WIDTH-1:0] v);
        logic [63:0] wide;
        wide = 64'(v);
        if (wide > OUT_MAX64) begin
            return '1;
        end
        return OUT_W'(wide);
    endfunction

endpackage

/* rtl/bucketed_value_histogram.sv */
// Bucketed value histogram: top level with handshake, configuration and result registers.
// Takes one transaction per clock while the output is not stalled: a transaction is held
// in the input register while its bucket count is read, updated and written back, and its
// result is then loaded into the output register, which offers it downstream.
// The read-modify-write of the bucket counts and totals sets the rate of one transaction
// per cycle while the result can advance. The output register holds a result while the
// downstream side stalls and the input side keeps accepting as long as the result can
// advance. Bounds are compared as written; software must write them in ascending order,
// which the block itself does not enforce.
module bucketed_value_histogram (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  bvh_pkg::t_in_item                 i_in_item,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output bvh_pkg::t_out_item                o_out_item,
    input  logic                              i_cfg_wr_en,
    input  logic [bvh_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bvh_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    logic                          r_bounds_in_use_v;
    logic [bvh_pkg::SEL_W-1:0]     r_bounds_in_use;
    bvh_pkg::t_bound               r_bounds [bvh_pkg::NUM_BOUNDS];

    logic                          r_in_valid;
    bvh_pkg::t_in_item             r_in_item;
    logic                          r_out_valid;
    bvh_pkg::t_out_item            r_out_item;

    logic                          w_fire;
    logic [bvh_pkg::SEL_W-1:0]     w_active;
    bvh_pkg::t_class               w_class;
    bvh_pkg::t_out_item            w_result;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bounds_in_use   <= bvh_pkg::SEL_W'(7);
            r_bounds_in_use_v <= 1'b1;
            for (int i = 0; i < bvh_pkg::NUM_BOUNDS; i++) begin
                r_bounds[i] <= '0;
            end
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index == bvh_pkg::CFG_BOUNDS_IN_USE) begin
                r_bounds_in_use   <= i_cfg_data[bvh_pkg::SEL_W-1:0];
                r_bounds_in_use_v <= 1'b1;
            end
            for (int i = 0; i < bvh_pkg::NUM_BOUNDS; i++) begin
                if (i_cfg_index == bvh_pkg::CFG_BOUND_0 + bvh_pkg::CFG_IDX_W'(i)) begin
                    r_bounds[i] <= i_cfg_data[bvh_pkg::SAMPLE_W-1:0];
                end
            end
        end
    end

    // Limit the active bound count to the bounds that exist
    always_comb begin
        w_active = (r_bounds_in_use > bvh_pkg::SEL_W'(bvh_pkg::NUM_BOUNDS))
                 ? bvh_pkg::SEL_W'(bvh_pkg::NUM_BOUNDS) : r_bounds_in_use;
    end

    // Advance when the result register is free or being drained
    assign w_fire      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_fire;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_item <= w_result;
        end
    end

    bvh_classify u_classify (
        .i_sample (r_in_item.sample),
        .i_active (w_active),
        .i_bounds (r_bounds),
        .o_class  (w_class)
    );

    bvh_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_item   (r_in_item),
        .i_class  (w_class),
        .i_active (w_active),
        .o_result (w_result)
    );

    // The bound count register always holds a value once out of reset
    a_cfg_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bounds_in_use_v && (w_active <= bvh_pkg::SEL_W'(bvh_pkg::NUM_BOUNDS)))
        else $error("active bound count out of range");

    // A result waiting on a stalled output is not overwritten
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !w_fire)
        else $error("result register overwritten while stalled");

    // A transaction that advances reaches the result register in the next cycle
    a_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_out_valid)
        else $error("advanced transaction produced no result");

endmodule

/* rtl/bvh_classify.sv */
// Bucket classifier: compares a sample against the active bounds in parallel.
module bvh_classify (
    input  logic [bvh_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [bvh_pkg::SEL_W-1:0]    i_active,
    input  bvh_pkg::t_bound              i_bounds [bvh_pkg::NUM_BOUNDS],
    output bvh_pkg::t_class              o_class
);

    logic [bvh_pkg::NUM_BOUNDS-1:0] w_le;

    // Flag every active bound that the sample does not exceed
    always_comb begin
        for (int i = 0; i < bvh_pkg::NUM_BOUNDS; i++) begin
            w_le[i] = (bvh_pkg::SEL_W'(i) < i_active) && (i_sample <= i_bounds[i]);
        end
    end

    // Pick the lowest flagged bucket, else the overflow bucket
    always_comb begin
        o_class.hit = i_active;
        for (int i = bvh_pkg::NUM_BOUNDS - 1; i >= 0; i--) begin
            if (w_le[i]) begin
                o_class.hit = bvh_pkg::SEL_W'(i);
            end
        end
    end

endmodule

/* rtl/bvh_core.sv */
// Counter core: bucket counts, total count and sum with their update logic.
module bvh_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_fire,
    input  bvh_pkg::t_in_item            i_item,
    input  bvh_pkg::t_class              i_class,
    input  logic [bvh_pkg::SEL_W-1:0]    i_active,
    output bvh_pkg::t_out_item           o_result
);

    logic [bvh_pkg::COUNT_WIDTH-1:0] r_counts [bvh_pkg::NUM_BUCKETS];
    logic [bvh_pkg::COUNT_WIDTH-1:0] r_sample_count;
    logic [bvh_pkg::SUM_W-1:0]       r_sample_sum;

    logic [bvh_pkg::COUNT_WIDTH-1:0] n_bucket;
    logic [bvh_pkg::COUNT_WIDTH-1:0] n_sample_count;
    logic [bvh_pkg::SUM_W-1:0]       n_sample_sum;

    logic                            w_observe;
    logic                            w_clear;
    logic [bvh_pkg::SEL_W-1:0]       w_addr;
    logic                            w_in_range;
    logic [bvh_pkg::COUNT_WIDTH-1:0] w_cur;
    logic [bvh_pkg::SUM_W:0]         w_sum_ext;

    // Decode the operation; the spare code reads
    always_comb begin
        w_observe = 1'b0;
        w_clear   = 1'b0;
        case (i_item.operation)
            bvh_pkg::OP_OBSERVE: w_observe = 1'b1;
            bvh_pkg::OP_CLEAR:   w_clear   = 1'b1;
            default:             ;
        endcase
    end

    // Read the addressed bucket count
    always_comb begin
        w_addr     = w_observe ? i_class.hit : i_item.bucket_select;
        w_in_range = (w_addr <= i_active);
        w_cur      = r_counts[w_addr[bvh_pkg::BKT_ADDR_W-1:0]];
    end

    // Saturating increments and saturating sum
    always_comb begin
        n_bucket       = (w_cur == bvh_pkg::COUNT_MAX) ? w_cur
                       : w_cur + bvh_pkg::COUNT_WIDTH'(1);
        n_sample_count = (r_sample_count == bvh_pkg::COUNT_MAX) ? r_sample_count
                       : r_sample_count + bvh_pkg::COUNT_WIDTH'(1);
        w_sum_ext      = (bvh_pkg::SUM_W + 1)'(r_sample_sum)
                       + (bvh_pkg::SUM_W + 1)'(i_item.sample);
        n_sample_sum   = w_sum_ext[bvh_pkg::SUM_W] ? bvh_pkg::SUM_MAX
                       : w_sum_ext[bvh_pkg::SUM_W-1:0];
    end

    // Form the result transaction
    always_comb begin
        if (w_observe) begin
            o_result.bin_index   = i_class.hit;
            o_result.bin_count   = bvh_pkg::clamp_out(n_bucket);
            o_result.total_count = bvh_pkg::clamp_out(n_sample_count);
            o_result.total_sum   = n_sample_sum;
        end else if (w_clear) begin
            o_result.bin_index   = i_item.bucket_select;
            o_result.bin_count   = '0;
            o_result.total_count = '0;
            o_result.total_sum   = '0;
        end else begin
            o_result.bin_index   = i_item.bucket_select;
            o_result.bin_count   = w_in_range ? bvh_pkg::clamp_out(w_cur) : '0;
            o_result.total_count = bvh_pkg::clamp_out(r_sample_count);
            o_result.total_sum   = r_sample_sum;
        end
    end

    // Commit the state update when the transaction advances
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < bvh_pkg::NUM_BUCKETS; i++) begin
                r_counts[i] <= '0;
            end
            r_sample_count <= '0;
            r_sample_sum   <= '0;
        end else if (i_fire) begin
            if (w_clear) begin
                for (int i = 0; i < bvh_pkg::NUM_BUCKETS; i++) begin
                    r_counts[i] <= '0;
                end
                r_sample_count <= '0;
                r_sample_sum   <= '0;
            end else if (w_observe) begin
                r_counts[w_addr[bvh_pkg::BKT_ADDR_W-1:0]] <= n_bucket;
                r_sample_count <= n_sample_count;
                r_sample_sum   <= n_sample_sum;
            end
        end
    end

    // A clear leaves the totals at zero
    a_clear_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && w_clear) |=> (r_sample_count == '0 && r_sample_sum == '0))
        else $error("totals not zero after clear");

    // An unsaturated observe advances the total count by one
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && w_observe && r_sample_count != bvh_pkg::COUNT_MAX)
        |=> (r_sample_count == $past(r_sample_count) + bvh_pkg::COUNT_WIDTH'(1)))
        else $error("total count did not advance on observe");

    // Without an advancing transaction the sum holds
    a_sum_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> $stable(r_sample_sum))
        else $error("sum changed without a transaction");

    // An observe never hits a bucket above the overflow bucket
    a_hit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && w_observe) |-> (i_class.hit <= i_active))
        else $error("observe hit beyond overflow bucket");

endmodule

/* verif/bvh_checker.sv */
`timescale 1ns / 100ps
// Checker for the bucketed value histogram: tracks configuration, predicts and compares results.
module bvh_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  bvh_pkg::t_in_item              i_in_item,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  bvh_pkg::t_out_item             i_out_item,
    input  logic                           i_cfg_wr_en,
    input  logic [bvh_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bvh_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);

    // Shadow configuration
    logic [bvh_pkg::SEL_W-1:0]    bounds_active_reg;
    logic [bvh_pkg::SAMPLE_W-1:0] bound_shadow [bvh_pkg::NUM_BOUNDS];

    // Shadow histogram state
    logic [bvh_pkg::OUT_W-1:0] bucket_tally [bvh_pkg::NUM_BUCKETS];
    logic [bvh_pkg::OUT_W-1:0] samples_seen;
    logic [bvh_pkg::SUM_W-1:0] samples_total;

    bvh_pkg::t_out_item bucket_reports_due [$];
    int                 mismatches = 0;

    assign o_fail_count = mismatches;

    // Print one line per mismatch and count it
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] histogram mismatch: %s got 0x%0h, want 0x%0h",
                 $time, what, got, want);
        mismatches++;
    endtask

    // Apply one transaction to the shadow histogram and return the result it should give
    function automatic bvh_pkg::t_out_item count_transaction(input bvh_pkg::t_in_item req);
        bvh_pkg::t_out_item        res;
        logic [bvh_pkg::SEL_W-1:0] active;
        logic [bvh_pkg::SEL_W-1:0] hit;
        logic [bvh_pkg::SUM_W:0]   wide_sum;
        active = (bounds_active_reg > bvh_pkg::SEL_W'(bvh_pkg::NUM_BOUNDS))
               ? bvh_pkg::SEL_W'(bvh_pkg::NUM_BOUNDS) : bounds_active_reg;
        if (req.operation == bvh_pkg::OP_OBSERVE) begin
            // scan from the top down so that the lowest matching bound wins
            hit = active;
            for (int i = bvh_pkg::NUM_BOUNDS - 1; i >= 0; i--) begin
                if (bvh_pkg::SEL_W'(i) < active && req.sample <= bound_shadow[i]) begin
                    hit = bvh_pkg::SEL_W'(i);
                end
            end
            if (bucket_tally[hit] != '1) begin
                bucket_tally[hit] = bucket_tally[hit] + bvh_pkg::OUT_W'(1);
            end
            if (samples_seen != '1) begin
                samples_seen = samples_seen + bvh_pkg::OUT_W'(1);
            end
            wide_sum = (bvh_pkg::SUM_W + 1)'(samples_total)
                     + (bvh_pkg::SUM_W + 1)'(req.sample);
            samples_total = wide_sum[bvh_pkg::SUM_W] ? {bvh_pkg::SUM_W{1'b1}}
                          : wide_sum[bvh_pkg::SUM_W-1:0];
            res.bin_index = hit;
            res.bin_count = bucket_tally[hit];
        end else begin
            // read, clear and the unused code all report the selected bucket
            if (req.operation == bvh_pkg::OP_CLEAR) begin
                for (int i = 0; i < bvh_pkg::NUM_BUCKETS; i++) begin
                    bucket_tally[i] = '0;
                end
                samples_seen  = '0;
                samples_total = '0;
            end
            res.bin_index = req.bucket_select;
            res.bin_count = (req.bucket_select <= active) ?
                            bucket_tally[req.bucket_select] : '0;
        end
        res.total_count = samples_seen;
        res.total_sum   = samples_total;
        return res;
    endfunction

    // Watch the channels: track writes, predict accepted transactions, compare results
    always @(posedge i_clk) begin
        bvh_pkg::t_out_item want;
        bvh_pkg::t_out_item predicted;
        if (!i_rst_n) begin
            bounds_active_reg <= bvh_pkg::SEL_W'(bvh_pkg::NUM_BOUNDS);
            for (int i = 0; i < bvh_pkg::NUM_BOUNDS; i++) begin
                bound_shadow[i] <= '0;
            end
            for (int i = 0; i < bvh_pkg::NUM_BUCKETS; i++) begin
                bucket_tally[i] = '0;
            end
            samples_seen  = '0;
            samples_total = '0;
            bucket_reports_due.delete();
        end else begin
            if (i_cfg_wr_en) begin
                if (i_cfg_index == bvh_pkg::CFG_BOUNDS_IN_USE) begin
                    bounds_active_reg <= i_cfg_data[bvh_pkg::SEL_W-1:0];
                end else begin
                    bound_shadow[i_cfg_index - bvh_pkg::CFG_BOUND_0] <= i_cfg_data;
                end
            end
            if (i_in_valid && i_in_ready) begin
                predicted = count_transaction(i_in_item);
                bucket_reports_due = {bucket_reports_due, predicted};
            end
            if (i_out_valid && i_out_ready) begin
                if (bucket_reports_due.size() == 0) begin
                    report_mismatch("result with nothing outstanding",
                                    64'(i_out_item.bin_count), '0);
                end else begin
                    want = bucket_reports_due.pop_front();
                    if (i_out_item.bin_index != want.bin_index) begin
                        report_mismatch("bin_index", 64'(i_out_item.bin_index),
                                        64'(want.bin_index));
                    end
                    if (i_out_item.bin_count != want.bin_count) begin
                        report_mismatch("bin_count", 64'(i_out_item.bin_count),
                                        64'(want.bin_count));
                    end
                    if (i_out_item.total_count != want.total_count) begin
                        report_mismatch("total_count", 64'(i_out_item.total_count),
                                        64'(want.total_count));
                    end
                    if (i_out_item.total_sum != want.total_sum) begin
                        report_mismatch("total_sum", 64'(i_out_item.total_sum),
                                        64'(want.total_sum));
                    end
                end
            end
        end
        o_pending <= bucket_reports_due.size();
    end

endmodule

/* verif/bucketed_value_histogram_tb.sv */
`timescale 1ns / 100ps
// Testbench top: clock, reset, stimulus phases and verdict for the bucketed value histogram.
module bucketed_value_histogram_tb;

    localparam logic [bvh_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT   = 2000;
    localparam int SEGMENT_ITEMS = 125;
    localparam int BURST_ITEMS   = 40;
    localparam logic [bvh_pkg::SAMPLE_W-1:0] ALL_ONES = '1;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic                           in_ready;
    bvh_pkg::t_in_item              in_item   = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    bvh_pkg::t_out_item             out_item;
    logic                           cfg_wr_en = 1'b0;
    logic [bvh_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [bvh_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    int fail_count;
    int results_outstanding;
    int idle_pct  = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;

    // Bound values staged for the next configuration burst
    logic [bvh_pkg::SAMPLE_W-1:0] bound_set [bvh_pkg::NUM_BOUNDS];

    bucketed_value_histogram u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    bvh_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (results_outstanding)
    );

    // Clock
    initial begin
        forever #1 clk = ~clk;
    end

    // Stall the result side at the current rate
    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Offer one transaction, with a random gap first, and hold it until accepted
    task automatic send_request(input logic [bvh_pkg::OP_W-1:0] op,
                                input logic [bvh_pkg::SAMPLE_W-1:0] value,
                                input logic [bvh_pkg::SEL_W-1:0] sel);
        bvh_pkg::t_in_item req;
        req.operation     = op;
        req.sample        = value;
        req.bucket_select = sel;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
        in_valid <= 1'b1;
        in_item  <= req;
        do @(posedge clk); while (!in_ready);
    endtask

    // Hold off the sender until every outstanding result has come back
    task automatic wait_for_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (results_outstanding != 0);
    endtask

    // Drain and let the pipeline empty before touching the registers
    task automatic settle();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the active bound count and all staged bounds in one burst
    task automatic program_histogram(input logic [bvh_pkg::SEL_W-1:0] active);
        cfg_wr_en <= 1'b1;
        cfg_index <= bvh_pkg::CFG_BOUNDS_IN_USE;
        cfg_data  <= bvh_pkg::CFG_DATA_W'(active);
        @(posedge clk);
        for (int k = 0; k < bvh_pkg::NUM_BOUNDS; k++) begin
            cfg_index <= bvh_pkg::CFG_BOUND_0 + bvh_pkg::CFG_IDX_W'(k);
            cfg_data  <= bound_set[k];
            @(posedge clk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // Stage random bounds, sorted ascending unless an unordered set is wanted
    task automatic draw_bounds(input bit ordered);
        logic [bvh_pkg::SAMPLE_W-1:0] held;
        for (int k = 0; k < bvh_pkg::NUM_BOUNDS; k++) begin
            case ($urandom_range(7))
                0:       bound_set[k] = '0;
                1:       bound_set[k] = ALL_ONES;
                default: bound_set[k] = $urandom >> $urandom_range(31);
            endcase
        end
        if (ordered) begin
            for (int k = 1; k < bvh_pkg::NUM_BOUNDS; k++) begin
                for (int j = k; j > 0; j--) begin
                    if (bound_set[j-1] > bound_set[j]) begin
                        held           = bound_set[j];
                        bound_set[j]   = bound_set[j-1];
                        bound_set[j-1] = held;
                    end
                end
            end
        end
    endtask

    // Pick a value near a bound, of random magnitude, or fully random
    function automatic logic [bvh_pkg::SAMPLE_W-1:0] pick_value();
        case ($urandom_range(9))
            0, 1, 2, 3: return bound_set[$urandom_range(bvh_pkg::NUM_BOUNDS - 1)]
                               + bvh_pkg::SAMPLE_W'($urandom_range(2))
                               - bvh_pkg::SAMPLE_W'(1);
            4, 5, 6, 7: return $urandom >> $urandom_range(31);
            default:    return $urandom;
        endcase
    endfunction

    function automatic logic [bvh_pkg::OP_W-1:0] pick_operation();
        int r;
        r = $urandom_range(99);
        if (r < 75) return bvh_pkg::OP_OBSERVE;
        if (r < 88) return bvh_pkg::OP_READ;
        if (r < 92) return bvh_pkg::OP_CLEAR;
        return OP_UNUSED;
    endfunction

    // Stimulus
    initial begin
        logic [bvh_pkg::SEL_W-1:0] active;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        settle();

        // Ascending bounds: boundaries, top bound, overflow, every operation
        bound_set = '{32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000, 32'd1000000,
                      32'hFFFF_FFFE};
        program_histogram(3'd7);
        settle();
        send_request(bvh_pkg::OP_OBSERVE, 32'd0, 3'd0);
        send_request(bvh_pkg::OP_OBSERVE, 32'd10, 3'd7);
        send_request(bvh_pkg::OP_OBSERVE, 32'd11, 3'd0);
        send_request(bvh_pkg::OP_OBSERVE, 32'hFFFF_FFFE, 3'd0);
        send_request(bvh_pkg::OP_OBSERVE, ALL_ONES, 3'd0);
        send_request(bvh_pkg::OP_READ, 32'd0, 3'd7);
        send_request(bvh_pkg::OP_READ, ALL_ONES, 3'd0);
        send_request(OP_UNUSED, ALL_ONES, 3'd1);
        send_request(bvh_pkg::OP_CLEAR, 32'd0, 3'd3);
        send_request(bvh_pkg::OP_READ, 32'd0, 3'd0);
        settle();

        // No active bounds: bucket 0 is the overflow bucket, anything above reads zero
        bound_set = '{default: ALL_ONES};
        program_histogram(3'd0);
        settle();
        send_request(bvh_pkg::OP_OBSERVE, 32'd0, 3'd0);
        send_request(bvh_pkg::OP_OBSERVE, ALL_ONES, 3'd0);
        send_request(bvh_pkg::OP_READ, 32'd0, 3'd1);
        settle();

        // Unordered bounds: the lowest-indexed matching bound wins
        bound_set = '{32'd1000, 32'd100, 32'd10, ALL_ONES, 32'd0, 32'd0, 32'd0};
        program_histogram(3'd3);
        settle();
        send_request(bvh_pkg::OP_OBSERVE, 32'd50, 3'd0);
        send_request(bvh_pkg::OP_OBSERVE, 32'd5, 3'd0);
        send_request(bvh_pkg::OP_OBSERVE, 32'd5000, 3'd0);
        send_request(bvh_pkg::OP_READ, 32'd0, 3'd5);
        settle();

        // Shrink the bound count over a filled bucket, then grow it back
        bound_set = '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, ALL_ONES};
        program_histogram(3'd7);
        settle();
        send_request(bvh_pkg::OP_OBSERVE, 32'd0, 3'd0);
        send_request(bvh_pkg::OP_OBSERVE, 32'd7, 3'd0);
        settle();
        program_histogram(3'd2);
        settle();
        send_request(bvh_pkg::OP_READ, 32'd0, 3'd6);
        send_request(bvh_pkg::OP_OBSERVE, 32'd9, 3'd0);
        settle();
        program_histogram(3'd7);
        settle();
        send_request(bvh_pkg::OP_READ, 32'd0, 3'd6);
        send_request(bvh_pkg::OP_READ, 32'd0, 3'd2);
        settle();

        // Push near-maximum samples back to back to grow the running sum quickly
        send_request(bvh_pkg::OP_CLEAR, 32'd0, 3'd0);
        for (int n = 0; n < BURST_ITEMS; n++) begin
            send_request(bvh_pkg::OP_OBSERVE,
                         ALL_ONES - bvh_pkg::SAMPLE_W'($urandom_range(1)), 3'd0);
        end
        send_request(bvh_pkg::OP_READ, 32'd0, 3'd7);
        send_request(bvh_pkg::OP_OBSERVE, ALL_ONES, 3'd0);
        send_request(bvh_pkg::OP_CLEAR, 32'd0, 3'd4);
        settle();

        // Random traffic: four idling phases, three configurations each
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 45; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 45; end
                default: begin idle_pct = 28; stall_pct = 28; end
            endcase
            for (int seg = 0; seg < 3; seg++) begin
                if (seg == 0) begin
                    active = 3'd7;
                end else if (ph == 3 && seg == 1) begin
                    active = 3'd0;
                end else begin
                    active = bvh_pkg::SEL_W'($urandom_range(6));
                end
                draw_bounds($urandom_range(5) != 0);
                program_histogram(active);
                settle();
                for (int n = 0; n < SEGMENT_ITEMS; n++) begin
                    // pause mid-stream until the pipeline has emptied
                    if (n == SEGMENT_ITEMS / 2) begin
                        wait_for_results();
                    end
                    send_request(pick_operation(), pick_value(),
                                 bvh_pkg::SEL_W'($urandom_range(7)));
                end
                settle();
            end
        end

        if (fail_count == 0 && results_outstanding == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
